@@ src/tmnm_pkg.sv @@
`default_nettype none
package tmnm_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_TILES     = 256;
    localparam int MAX_TILE_SIZE = 64;

    localparam int DIV_NUM_W = 28;
    localparam int DIV_DEN_W = 13;
    localparam int DIV_CNT_W = 5;

    localparam logic [1:0] CFG_FRAME_WIDTH = 2'd0;
    localparam logic [1:0] CFG_TILE_SIZE   = 2'd1;
    localparam logic [1:0] CFG_TILE_COUNT  = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_RS_GO     = 9'b000000010,
        ST_RS_WAIT   = 9'b000000100,
        ST_PROC0     = 9'b000001000,
        ST_PROC1     = 9'b000010000,
        ST_MEAN_GO   = 9'b000100000,
        ST_MEAN_WAIT = 9'b001000000,
        ST_SEARCH    = 9'b010000000,
        ST_OUT       = 9'b100000000
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
        logic [DIV_DEN_W-1:0] rem;
    } div_rsp_t;

endpackage
`default_nettype wire

@@ src/tile_mean_nearest_match_top.sv @@
// Each request is taken one at a time. After a register write the next pixel
// first recomputes its tile position in the shared 28-step divider. A pixel
// that completes a tile also runs the mean division and the table search,
// one entry read per cycle.
// Reset is synchronous and active low; it restores the register defaults.
`default_nettype none
module tile_mean_nearest_match_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // entry_index, entry_mean, pixel
    input  wire  [31:0] s_tdata,
    // req_type, frame_start
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // tile_row, tile_col, best_index, block_mean, zero padding
    output logic [47:0] m_tdata,
    output logic        m_tlast,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [10:0] cfg_data
);
    import tmnm_pkg::*;

    state_t state_reg, state_next;

    logic [10:0] fw_raw_reg;
    logic [6:0]  ts_raw_reg;
    logic [8:0]  tn_raw_reg;
    logic [10:0] w_cl;
    logic [6:0]  t_cl;
    logic [8:0]  n_cl;

    logic [10:0] col_reg, col_next, row_reg, row_next;
    logic [6:0]  cm_reg, cm_next, rm_reg, rm_next;
    logic [10:0] tc_reg, tc_next, tr_reg, tr_next;
    logic [10:0] tpr_reg, tpr_next;
    logic [12:0] tsq_reg, tsq_next;
    logic        dirty_reg, dirty_next;
    logic [1:0]  rs_step_reg, rs_step_next;
    logic [7:0]  pix_reg, pix_next;
    logic [19:0] sum_reg, sum_next;
    logic [27:0] mean_reg, mean_next;
    logic [9:0]  res_tr_reg, res_tr_next, res_tc_reg, res_tc_next;
    logic        res_last_reg, res_last_next;
    logic [8:0]  rd_cnt_reg, rd_cnt_next;
    logic        cmp_valid_reg, cmp_valid_next;
    logic [7:0]  cmp_idx_reg, cmp_idx_next;
    logic [7:0]  best_idx_reg, best_idx_next;
    logic [27:0] best_d_reg, best_d_next;

    logic        m_valid_reg, m_valid_next;
    logic [47:0] m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;

    logic [19:0] col_mem [MAX_WIDTH];
    logic [19:0] col_rd_reg;
    logic        col_re, col_we;
    logic [19:0] col_wdata;
    logic [15:0] tab_mem [MAX_TILES];
    logic [15:0] tab_rd_reg;
    logic        tab_re, tab_we;
    logic [7:0]  tab_raddr;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [10:0] c0, r0, c1, r1;
    logic        in_tile, first_px, last_px;
    logic [27:0] d;
    logic [13:0] tsq_full;

    tmnm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        w_cl = (fw_raw_reg == '0) ? 11'd1 :
               (fw_raw_reg > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : fw_raw_reg;
        t_cl = (ts_raw_reg == '0) ? 7'd1 :
               (ts_raw_reg > 7'(MAX_TILE_SIZE)) ? 7'(MAX_TILE_SIZE) : ts_raw_reg;
        n_cl = (tn_raw_reg == '0) ? 9'd1 :
               (tn_raw_reg > 9'(MAX_TILES)) ? 9'(MAX_TILES) : tn_raw_reg;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign tsq_full  = 14'({7'd0, t_cl} * {7'd0, t_cl});

    always_comb begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cm_next        = cm_reg;
        rm_next        = rm_reg;
        tc_next        = tc_reg;
        tr_next        = tr_reg;
        tpr_next       = tpr_reg;
        tsq_next       = tsq_reg;
        dirty_next     = dirty_reg;
        rs_step_next   = rs_step_reg;
        pix_next       = pix_reg;
        sum_next       = sum_reg;
        mean_next      = mean_reg;
        res_tr_next    = res_tr_reg;
        res_tc_next    = res_tc_reg;
        res_last_next  = res_last_reg;
        rd_cnt_next    = rd_cnt_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        best_idx_next  = best_idx_reg;
        best_d_next    = best_d_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        col_re         = 1'b0;
        col_we         = 1'b0;
        col_wdata      = '0;
        tab_re         = 1'b0;
        tab_we         = 1'b0;
        tab_raddr      = rd_cnt_reg[7:0];
        div_req        = '0;
        c0             = s_tuser[1] ? '0 : col_reg;
        r0             = s_tuser[1] ? '0 : row_reg;
        c1             = (c0 >= w_cl) ? '0 : c0;
        r1             = (c0 >= w_cl) ? r0 + 1'b1 : r0;
        in_tile        = (tc_reg < tpr_reg) && (tr_reg < tpr_reg);
        first_px       = (cm_reg == '0) && (rm_reg == '0);
        last_px        = (cm_reg == t_cl - 1'b1) && (rm_reg == t_cl - 1'b1);
        d              = (mean_reg > {12'd0, tab_rd_reg}) ? mean_reg - {12'd0, tab_rd_reg}
                                                         : {12'd0, tab_rd_reg} - mean_reg;

        if (cfg_valid) begin
            dirty_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == REQ_LOAD) begin
                        tab_we = 1'b1;
                    end else begin
                        pix_next = s_tdata[31:24];
                        if (s_tuser[1]) begin
                            cm_next = '0;
                            rm_next = '0;
                            tc_next = '0;
                            tr_next = '0;
                        end
                        if (dirty_reg) begin
                            col_next     = c1;
                            row_next     = (r1 >= w_cl) ? '0 : r1;
                            rs_step_next = '0;
                            state_next   = ST_RS_GO;
                        end else begin
                            col_next   = c0;
                            row_next   = r0;
                            state_next = ST_PROC0;
                        end
                    end
                end
            end
            ST_RS_GO: begin
                div_req.start = 1'b1;
                div_req.den   = 13'(t_cl);
                case (rs_step_reg)
                    2'd0:    div_req.num = 28'(w_cl);
                    2'd1:    div_req.num = 28'(col_reg);
                    default: div_req.num = 28'(row_reg);
                endcase
                state_next = ST_RS_WAIT;
            end
            ST_RS_WAIT: begin
                if (div_rsp.done) begin
                    case (rs_step_reg)
                        2'd0: begin
                            tpr_next = div_rsp.quo[10:0];
                            tsq_next = tsq_full[12:0];
                        end
                        2'd1: begin
                            tc_next = div_rsp.quo[10:0];
                            cm_next = div_rsp.rem[6:0];
                        end
                        default: begin
                            tr_next = div_rsp.quo[10:0];
                            rm_next = div_rsp.rem[6:0];
                        end
                    endcase
                    if (rs_step_reg == 2'd2) begin
                        dirty_next = cfg_valid;
                        state_next = ST_PROC0;
                    end else begin
                        rs_step_next = rs_step_reg + 1'b1;
                        state_next   = ST_RS_GO;
                    end
                end
            end
            ST_PROC0: begin
                col_re     = 1'b1;
                state_next = ST_PROC1;
            end
            ST_PROC1: begin
                col_wdata     = (first_px ? 20'd0 : col_rd_reg) + {12'd0, pix_reg};
                col_we        = in_tile;
                sum_next      = col_wdata;
                res_tr_next   = tr_reg[9:0];
                res_tc_next   = tc_reg[9:0];
                res_last_next = (tr_reg == tpr_reg - 1'b1) && (tc_reg == tpr_reg - 1'b1);
                if (col_reg + 1'b1 >= w_cl) begin
                    col_next = '0;
                    cm_next  = '0;
                    tc_next  = '0;
                    if (row_reg + 1'b1 >= w_cl) begin
                        row_next = '0;
                        rm_next  = '0;
                        tr_next  = '0;
                    end else begin
                        row_next = row_reg + 1'b1;
                        if (rm_reg + 1'b1 == t_cl) begin
                            rm_next = '0;
                            tr_next = tr_reg + 1'b1;
                        end else begin
                            rm_next = rm_reg + 1'b1;
                        end
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                    if (cm_reg + 1'b1 == t_cl) begin
                        cm_next = '0;
                        tc_next = tc_reg + 1'b1;
                    end else begin
                        cm_next = cm_reg + 1'b1;
                    end
                end
                state_next = (in_tile && last_px) ? ST_MEAN_GO : ST_IDLE;
            end
            ST_MEAN_GO: begin
                div_req.start = 1'b1;
                div_req.num   = {sum_reg, 8'd0};
                div_req.den   = tsq_reg;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (div_rsp.done) begin
                    mean_next   = div_rsp.quo;
                    rd_cnt_next = '0;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (rd_cnt_reg < n_cl) begin
                    tab_re         = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_cnt_reg[7:0];
                    rd_cnt_next    = rd_cnt_reg + 1'b1;
                end
                if (cmp_valid_reg) begin
                    if (cmp_idx_reg == '0 || d < best_d_reg) begin
                        best_d_next   = d;
                        best_idx_next = cmp_idx_reg;
                    end
                    if ({1'b0, cmp_idx_reg} == n_cl - 1'b1) begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'd0, mean_reg[15:0], best_idx_reg, res_tc_reg, res_tr_reg};
                    m_last_next  = res_last_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (col_we) begin
            col_mem[tc_reg[9:0]] <= col_wdata;
        end
        if (col_re) begin
            col_rd_reg <= col_mem[tc_reg[9:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (tab_we) begin
            tab_mem[s_tdata[7:0]] <= s_tdata[23:8];
        end
        if (tab_re) begin
            tab_rd_reg <= tab_mem[tab_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fw_raw_reg    <= 11'd512;
            ts_raw_reg    <= 7'd16;
            tn_raw_reg    <= 9'd256;
            col_reg       <= '0;
            row_reg       <= '0;
            cm_reg        <= '0;
            rm_reg        <= '0;
            tc_reg        <= '0;
            tr_reg        <= '0;
            tpr_reg       <= '0;
            tsq_reg       <= 13'd1;
            dirty_reg     <= 1'b1;
            rs_step_reg   <= '0;
            rd_cnt_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH: fw_raw_reg <= cfg_data;
                    CFG_TILE_SIZE:   ts_raw_reg <= cfg_data[6:0];
                    CFG_TILE_COUNT:  tn_raw_reg <= cfg_data[8:0];
                    default:         ;
                endcase
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            cm_reg        <= cm_next;
            rm_reg        <= rm_next;
            tc_reg        <= tc_next;
            tr_reg        <= tr_next;
            tpr_reg       <= tpr_next;
            tsq_reg       <= tsq_next;
            dirty_reg     <= dirty_next;
            rs_step_reg   <= rs_step_next;
            rd_cnt_reg    <= rd_cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        pix_reg      <= pix_next;
        sum_reg      <= sum_next;
        mean_reg     <= mean_next;
        res_tr_reg   <= res_tr_next;
        res_tc_reg   <= res_tc_next;
        res_last_reg <= res_last_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_d_reg   <= best_d_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

@@ src/tmnm_div.sv @@
`default_nettype none
module tmnm_div (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  tmnm_pkg::div_req_t  req,
    output tmnm_pkg::div_rsp_t  rsp
);
    import tmnm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    always_comb begin
        shifted   = {rem_reg, num_reg[DIV_NUM_W-1]};
        ge        = shifted >= {1'b0, den_reg};
        diff      = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            num_next = {num_reg[DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

@@ src/tmnm_chk.sv @@
`default_nettype none
module tmnm_chk (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [47:0] m_tdata,
    input wire        cfg_ready
);

    // A result is never raised in the cycle straight after a request is taken.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result raised directly after a request");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:44] == 4'd0)
        else $error("result padding not zero");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind tile_mean_nearest_match_top tmnm_chk u_tmnm_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);
`default_nettype wire
